// ----- hw/rtl/hci_ccp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HCI command-complete parser package
// Phase encoding and protocol constants shared by the parser.
// ----------------------------------------------------------------------------
package hci_ccp_pkg;

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_TYPE    = 3'd3,
        PH_OP_LO   = 3'd4,
        PH_OP_HI   = 3'd5,
        PH_STATUS  = 3'd6,
        PH_PAYLOAD = 3'd7
    } t_phase;

    localparam logic [7:0]  C_SYNC_FIRST   = 8'h04;
    localparam logic [7:0]  C_SYNC_SECOND  = 8'h0E;
    localparam logic [7:0]  C_PKT_TYPE     = 8'h01;
    localparam logic [7:0]  C_STATUS_OK    = 8'h00;
    localparam logic [7:0]  C_HDR_BYTES    = 8'd4;
    localparam logic [15:0] C_EARLY_RESET  = 16'hFC4E;
    localparam int unsigned C_MAX_PAYLOAD  = 240;
    localparam logic [8:0]  C_MAX_LEN_BYTE = 9'(C_MAX_PAYLOAD + 4);

endpackage

// ----- hw/rtl/hci_command_complete_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HCI command-complete parser, top level
// Results are registered: an accepted byte is held in the input register,
//   and the phase logic then loads the result register from it.
// Throughput: one byte per cycle unless a stalled result holds the byte.
// Reset: i_rst_n is synchronous, active low; clears phase, counters,
//   valid flags and sets the early-end opcode to 0xFC4E.
// ----------------------------------------------------------------------------
module hci_command_complete_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write: early_end_opcode
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // input bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] event_opcode, [23:16] data_byte,
                                        // [31:24] data_index, [39:32] data_length
    output logic        m_axis_tuser,   // [0] has_data
    output logic        m_axis_tlast    // is_last
);

    logic [15:0] r_early_op;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    hci_ccp_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_opcode, n_opcode;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_count, n_count;

    logic        r_out_valid;
    logic [15:0] r_out_opcode;
    logic [7:0]  r_out_byte;
    logic [7:0]  r_out_index;
    logic [7:0]  r_out_length;
    logic        r_out_has;
    logic        r_out_last;

    logic        emit;
    logic [7:0]  emit_byte;
    logic [7:0]  emit_index;
    logic        emit_has;
    logic        emit_last;
    logic        advance;
    logic [7:0]  cnt_inc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_early_op <= hci_ccp_pkg::C_EARLY_RESET;
        end else if (i_cfg_valid) begin
            r_early_op <= i_cfg_data;
        end
    end

    // Phase logic on the registered byte
    always_comb begin
        n_phase    = r_phase;
        n_opcode   = r_opcode;
        n_len      = r_len;
        n_count    = r_count;
        emit       = 1'b0;
        emit_byte  = 8'd0;
        emit_index = 8'd0;
        emit_has   = 1'b0;
        emit_last  = 1'b0;
        cnt_inc    = r_count + 8'd1;
        case (r_phase)
            hci_ccp_pkg::PH_SYNC1: begin
                if (r_in_byte == hci_ccp_pkg::C_SYNC_FIRST) begin
                    n_opcode = 16'd0;
                    n_len    = 8'd0;
                    n_count  = 8'd0;
                    n_phase  = hci_ccp_pkg::PH_SYNC2;
                end
            end
            hci_ccp_pkg::PH_SYNC2: begin
                n_phase = (r_in_byte == hci_ccp_pkg::C_SYNC_SECOND) ?
                          hci_ccp_pkg::PH_LENGTH : hci_ccp_pkg::PH_SYNC1;
            end
            hci_ccp_pkg::PH_LENGTH: begin
                if (r_in_byte >= hci_ccp_pkg::C_HDR_BYTES &&
                    {1'b0, r_in_byte} <= hci_ccp_pkg::C_MAX_LEN_BYTE) begin
                    n_len   = r_in_byte - hci_ccp_pkg::C_HDR_BYTES;
                    n_phase = hci_ccp_pkg::PH_TYPE;
                end else begin
                    n_phase = hci_ccp_pkg::PH_SYNC1;
                end
            end
            hci_ccp_pkg::PH_TYPE: begin
                n_phase = (r_in_byte == hci_ccp_pkg::C_PKT_TYPE) ?
                          hci_ccp_pkg::PH_OP_LO : hci_ccp_pkg::PH_SYNC1;
            end
            hci_ccp_pkg::PH_OP_LO: begin
                n_opcode = {r_opcode[15:8], r_in_byte};
                n_phase  = hci_ccp_pkg::PH_OP_HI;
            end
            hci_ccp_pkg::PH_OP_HI: begin
                n_opcode = {r_in_byte, r_opcode[7:0]};
                n_phase  = hci_ccp_pkg::PH_STATUS;
            end
            hci_ccp_pkg::PH_STATUS: begin
                if (r_in_byte != hci_ccp_pkg::C_STATUS_OK) begin
                    n_phase = hci_ccp_pkg::PH_SYNC1;
                end else if (r_opcode == r_early_op || r_len == 8'd0) begin
                    // header-only completion
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    n_phase   = hci_ccp_pkg::PH_SYNC1;
                end else begin
                    n_phase = hci_ccp_pkg::PH_PAYLOAD;
                end
            end
            hci_ccp_pkg::PH_PAYLOAD: begin
                emit       = 1'b1;
                emit_byte  = r_in_byte;
                emit_index = r_count;
                emit_has   = 1'b1;
                emit_last  = (cnt_inc >= r_len);
                n_count    = cnt_inc;
                if (emit_last) begin
                    n_phase = hci_ccp_pkg::PH_SYNC1;
                end
            end
            default: begin
                n_phase = hci_ccp_pkg::PH_SYNC1;
            end
        endcase
    end

    // Advance the held byte unless its result would overwrite a stalled one
    assign advance       = r_in_valid && (!emit || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hci_ccp_pkg::PH_SYNC1;
            r_opcode <= 16'd0;
            r_len    <= 8'd0;
            r_count  <= 8'd0;
        end else if (advance) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_len    <= n_len;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_opcode <= n_opcode;
            r_out_byte   <= emit_byte;
            r_out_index  <= emit_index;
            r_out_length <= n_len;
            r_out_has    <= emit_has;
            r_out_last   <= emit_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_length, r_out_index, r_out_byte, r_out_opcode};
    assign m_axis_tuser  = r_out_has;
    assign m_axis_tlast  = r_out_last;

    // A header-only result always closes the event
    a_hdr_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_has) |-> r_out_last)
        else $error("header-only result without is_last");

    a_hdr_only_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_has) |-> (r_out_byte == 8'd0 && r_out_index == 8'd0))
        else $error("header-only result carries data");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_has) |-> (r_out_index < r_out_length))
        else $error("payload index beyond length");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_has && r_out_last) |-> (r_out_index == r_out_length - 8'd1))
        else $error("last payload byte at wrong index");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HCI command-complete parser testbench
// Feeds received bytes and checks every streamed payload beat and every
// header-only completion against a byte-level model of the event parser.
// A short table of hand-picked bytes comes first. Random well-formed events,
// broken headers and line noise follow, under four early-end opcode settings,
// with random gaps on the byte side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned PHASE_BYTES    = 330;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_GAP        = 18;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef struct packed {
        logic [15:0] opcode;
        logic [7:0]  data;
        logic [7:0]  index;
        logic [7:0]  length;
        logic        has_data;
        logic        is_last;
    } t_payload_beat;

    // pinned rows carry a beat typed in by hand; all others use the model
    typedef struct packed {
        logic [7:0]    rx;
        logic          pinned;
        t_payload_beat beat;
    } t_stim_row;

    localparam t_payload_beat NO_BEAT = '0;

    localparam t_stim_row DIRECTED_ROWS [25] = '{
        // empty payload, opcode all zeros: completes at the status byte
        '{8'h04, 1'b0, NO_BEAT}, '{8'h0E, 1'b0, NO_BEAT}, '{8'h04, 1'b0, NO_BEAT},
        '{8'h01, 1'b0, NO_BEAT}, '{8'h00, 1'b0, NO_BEAT}, '{8'h00, 1'b0, NO_BEAT},
        '{8'h00, 1'b1, '{16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
        // early-end opcode with two payload bytes left behind
        '{8'h04, 1'b0, NO_BEAT}, '{8'h0E, 1'b0, NO_BEAT}, '{8'h06, 1'b0, NO_BEAT},
        '{8'h01, 1'b0, NO_BEAT}, '{8'h4E, 1'b0, NO_BEAT}, '{8'hFC, 1'b0, NO_BEAT},
        '{8'h00, 1'b1, '{16'hFC4E, 8'h00, 8'h00, 8'h02, 1'b0, 1'b1}},
        // leftover payload bytes become a fresh sync, then the length 3 fails
        '{8'h04, 1'b0, NO_BEAT}, '{8'h0E, 1'b0, NO_BEAT}, '{8'h03, 1'b0, NO_BEAT},
        // one payload byte, opcode and data all ones
        '{8'h04, 1'b0, NO_BEAT}, '{8'h0E, 1'b0, NO_BEAT}, '{8'h05, 1'b0, NO_BEAT},
        '{8'h01, 1'b0, NO_BEAT}, '{8'hFF, 1'b0, NO_BEAT}, '{8'hFF, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'hFF, 1'b1, '{16'hFFFF, 8'hFF, 8'h00, 8'h01, 1'b1, 1'b1}}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // parser model state
    hci_ccp_pkg::t_phase parse_phase;
    logic [15:0] opcode_acc;
    logic [7:0]  pay_len;
    logic [7:0]  pay_cnt;
    logic [15:0] early_end_op;

    t_payload_beat beats_due [$];
    logic [7:0]    pending_rx [$];
    t_payload_beat got_beat;
    t_payload_beat want_beat;

    int unsigned bytes_sent;
    int unsigned beats_seen;
    int unsigned events_done;
    int unsigned settings_used;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    int unsigned drain_gap;
    bit          feed_burst;
    bit          drain_burst;

    hci_command_complete_parser_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Advance the parser by one byte; report the beat it completes, if any.
    function automatic void parse_byte(input logic [7:0] b, output bit gives,
                                       output t_payload_beat beat);
        logic [7:0] slot;
        gives = 1'b0;
        beat  = '0;
        case (parse_phase)
            hci_ccp_pkg::PH_SYNC1: begin
                if (b == hci_ccp_pkg::C_SYNC_FIRST) begin
                    opcode_acc  = '0;
                    pay_len     = '0;
                    pay_cnt     = '0;
                    parse_phase = hci_ccp_pkg::PH_SYNC2;
                end
            end
            hci_ccp_pkg::PH_SYNC2: begin
                parse_phase = (b == hci_ccp_pkg::C_SYNC_SECOND) ?
                              hci_ccp_pkg::PH_LENGTH : hci_ccp_pkg::PH_SYNC1;
            end
            hci_ccp_pkg::PH_LENGTH: begin
                if (b >= hci_ccp_pkg::C_HDR_BYTES &&
                    {1'b0, b} <= hci_ccp_pkg::C_MAX_LEN_BYTE) begin
                    pay_len     = b - hci_ccp_pkg::C_HDR_BYTES;
                    parse_phase = hci_ccp_pkg::PH_TYPE;
                end else begin
                    parse_phase = hci_ccp_pkg::PH_SYNC1;
                end
            end
            hci_ccp_pkg::PH_TYPE: begin
                parse_phase = (b == hci_ccp_pkg::C_PKT_TYPE) ?
                              hci_ccp_pkg::PH_OP_LO : hci_ccp_pkg::PH_SYNC1;
            end
            hci_ccp_pkg::PH_OP_LO: begin
                opcode_acc[7:0] = b;
                parse_phase     = hci_ccp_pkg::PH_OP_HI;
            end
            hci_ccp_pkg::PH_OP_HI: begin
                opcode_acc[15:8] = b;
                parse_phase      = hci_ccp_pkg::PH_STATUS;
            end
            hci_ccp_pkg::PH_STATUS: begin
                if (b != hci_ccp_pkg::C_STATUS_OK) begin
                    parse_phase = hci_ccp_pkg::PH_SYNC1;
                end else if (opcode_acc == early_end_op || pay_len == 8'd0) begin
                    gives       = 1'b1;
                    beat        = '{opcode_acc, 8'h00, 8'h00, pay_len, 1'b0, 1'b1};
                    parse_phase = hci_ccp_pkg::PH_SYNC1;
                end else begin
                    parse_phase = hci_ccp_pkg::PH_PAYLOAD;
                end
            end
            default: begin
                slot    = pay_cnt;
                pay_cnt = pay_cnt + 8'd1;
                gives   = 1'b1;
                beat    = '{opcode_acc, b, slot, pay_len, 1'b1, pay_cnt >= pay_len};
                if (pay_cnt >= pay_len) begin
                    parse_phase = hci_ccp_pkg::PH_SYNC1;
                end
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic pinned,
                             input t_payload_beat pinned_beat);
        int unsigned   gap;
        bit            gives;
        t_payload_beat beat;
        gap = feed_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        parse_byte(b, gives, beat);
        if (pinned) begin
            beats_due.push_back(pinned_beat);
        end else if (gives) begin
            beats_due.push_back(beat);
        end
        bytes_sent++;
        if ($urandom_range(0, 39) == 0) feed_burst = !feed_burst;
    endtask

    // Queue one event, a broken header or a burst of line noise.
    task automatic build_packet();
        int unsigned kind;
        int unsigned pick;
        int unsigned cut;
        logic [7:0]  len_byte;
        logic [15:0] op;
        logic [7:0]  hdr [7];
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 6)) begin
                pending_rx.push_back(($urandom_range(0, 3) == 0) ?
                                     hci_ccp_pkg::C_SYNC_FIRST : 8'($urandom));
            end
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3)       len_byte = 8'(hci_ccp_pkg::C_MAX_LEN_BYTE);
            else if (pick < 15) len_byte = hci_ccp_pkg::C_HDR_BYTES;
            else                len_byte = 8'($urandom_range(5, 24));
            pick = $urandom_range(0, 99);
            if (pick < 35)      op = early_end_op;
            else if (pick < 40) op = 16'h0000;
            else if (pick < 45) op = 16'hFFFF;
            else                op = 16'($urandom);
            hdr = '{hci_ccp_pkg::C_SYNC_FIRST, hci_ccp_pkg::C_SYNC_SECOND, len_byte,
                    hci_ccp_pkg::C_PKT_TYPE, op[7:0], op[15:8], hci_ccp_pkg::C_STATUS_OK};
            if (kind < 30) begin
                // corrupt one checked header byte and stop there
                case ($urandom_range(0, 3))
                    0:       cut = 1;
                    1:       cut = 2;
                    2:       cut = 3;
                    default: cut = 6;
                endcase
                if (cut == 2) begin
                    hdr[2] = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                                  : 8'($urandom_range(245, 255));
                end else begin
                    hdr[cut] = hdr[cut] ^ 8'($urandom_range(1, 255));
                end
                for (int i = 0; i <= int'(cut); i++) pending_rx.push_back(hdr[i]);
            end else begin
                foreach (hdr[i]) pending_rx.push_back(hdr[i]);
                // with an early-end opcode these bytes fall back into sync search
                repeat (int'(len_byte) - int'(hci_ccp_pkg::C_HDR_BYTES)) begin
                    pending_rx.push_back(($urandom_range(0, 7) == 0) ?
                                         hci_ccp_pkg::C_SYNC_FIRST : 8'($urandom));
                end
            end
        end
    endtask

    task automatic run_random_phase();
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES) begin
            build_packet();
            while (pending_rx.size() != 0) send_byte(pending_rx.pop_front(), 1'b0, NO_BEAT);
        end
    endtask

    task automatic write_early_end(input logic [15:0] value);
        s_axis_tvalid <= 1'b0;
        while (beats_due.size() != 0) @(posedge i_clk);
        // a trailing byte may still be in flight without producing a beat
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        early_end_op  = value;
        settings_used++;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: beat %0d %s mismatch: expected %h, got %h",
                         $time, beats_seen, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_seen++;
            got_beat = '{m_axis_tdata[15:0], m_axis_tdata[23:16], m_axis_tdata[31:24],
                         m_axis_tdata[39:32], m_axis_tuser, m_axis_tlast};
            if (beats_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected beat, got %h", $time, got_beat);
                end
            end else begin
                want_beat = beats_due.pop_front();
                if (want_beat.is_last) events_done++;
                check_field("event_opcode", want_beat.opcode, got_beat.opcode);
                check_field("data_byte", 16'(want_beat.data), 16'(got_beat.data));
                check_field("data_index", 16'(want_beat.index), 16'(got_beat.index));
                check_field("data_length", 16'(want_beat.length), 16'(got_beat.length));
                check_field("has_data", 16'(want_beat.has_data), 16'(got_beat.has_data));
                check_field("is_last", 16'(want_beat.is_last), 16'(got_beat.is_last));
            end
        end
    end

    // Result side: stall a random number of cycles before each beat.
    initial begin
        wait (i_rst_n);
        forever begin
            drain_gap = drain_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (drain_gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (drain_gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            if ($urandom_range(0, 39) == 0) drain_burst = !drain_burst;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[hci_command_complete_parser_top] ERROR");
        $finish;
    end

    initial begin
        parse_phase  = hci_ccp_pkg::PH_SYNC1;
        opcode_acc   = '0;
        pay_len      = '0;
        pay_cnt      = '0;
        early_end_op = hci_ccp_pkg::C_EARLY_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[i]) begin
            send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].beat);
        end
        run_random_phase();
        write_early_end(16'h0000);
        run_random_phase();
        write_early_end(16'hFFFF);
        run_random_phase();
        write_early_end(16'($urandom));
        run_random_phase();

        s_axis_tvalid <= 1'b0;
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);

        $display("Sent %0d bytes under %0d early-end opcode writes plus the reset value",
                 bytes_sent, settings_used);
        $display("Checked %0d beats closing %0d events, %0d mismatches",
                 beats_seen, events_done, mismatches);
        if (mismatches == 0) begin
            $display("[hci_command_complete_parser_top] OK");
        end else begin
            $display("[hci_command_complete_parser_top] ERROR");
        end
        $finish;
    end

endmodule
